@@ sv/ctt_pkg.sv @@
package ctt_pkg;

    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] REG_GENERATION = 3'd0;
    localparam logic [2:0] REG_CLUSTERS   = 3'd1;
    localparam logic [2:0] REG_MATE_VALUE = 3'd2;
    localparam logic [2:0] REG_MATE_THR   = 3'd3;
    localparam logic [2:0] REG_TB_THR     = 3'd4;
    localparam logic [2:0] REG_NONE_VALUE = 3'd5;

    localparam logic [1:0] EXACT_BOUND = 2'd3;

    // Packed entry: tag, move, value, eval, age/bound, pv/depth
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] mv;
        logic [15:0] value;
        logic [15:0] eval;
        logic [7:0]  age_bound;
        logic [7:0]  depth_pv;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  generation;
        logic [12:0] clusters_in_use;
        logic [14:0] mate_value;
        logic [14:0] mate_threshold;
        logic [14:0] tablebase_threshold;
        logic [15:0] none_value;
    } cfg_t;

endpackage

@@ sv/ctt_entry_ram.sv @@
module ctt_entry_ram #(
    parameter int DEPTH = 12288,
    parameter int AW    = 14
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  ctt_pkg::entry_t       wdata,
    input  logic [AW-1:0]         raddr,
    output ctt_pkg::entry_t       rdata
);

    ctt_pkg::entry_t mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/clustered_transposition_table_top.sv @@
// Sequence: after accept, probe and store pass through an index state, a read and a scan state
// for each cluster entry, a write-back state and an output state that loads the result word.
// No new word is accepted until the result word has been handed over.
// Clear: walks every entry, one per cycle, then presents a result word.
// Reset: asynchronous, active low; after reset the same clearing pass runs before any word
// is accepted. Configuration returns to its defaults.
module clustered_transposition_table_top #(
    parameter int CLUSTERS            = 4096,
    parameter int ENTRIES_PER_CLUSTER = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] key,
    input  logic signed [15:0] value,
    input  logic signed [15:0] eval,
    input  logic [15:0] move,
    input  logic [1:0]  bound,
    input  logic [6:0]  depth,
    input  logic        pv,
    input  logic [7:0]  ply,
    input  logic [6:0]  rule50,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic signed [15:0] hit_value,
    output logic signed [15:0] hit_eval,
    output logic [15:0] hit_move,
    output logic [1:0]  hit_bound,
    output logic [6:0]  hit_depth,
    output logic        hit_pv
);

    localparam int SLOTS = CLUSTERS * ENTRIES_PER_CLUSTER;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(CLUSTERS + 1);
    localparam int EW    = (ENTRIES_PER_CLUSTER > 1) ? $clog2(ENTRIES_PER_CLUSTER) : 1;

    ctt_pkg::state_t state_reg, state_next;
    ctt_pkg::cfg_t   cfg_reg;
    logic            boot_reg;

    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [15:0] val_reg, eval_reg, mv_reg;
    logic [1:0]  bnd_reg;
    logic [6:0]  dep_reg;
    logic        pv_reg;
    logic [7:0]  ply_reg;
    logic [6:0]  r50_reg;

    logic [AW-1:0] base_reg, addr_reg, addr_next;
    logic [EW-1:0] idx_reg;
    logic          phase_reg;
    logic          hit_reg, empty_found_reg;
    logic [EW-1:0] pick_reg;
    logic signed [9:0] pick_score_reg;
    ctt_pkg::entry_t   pick_ent_reg, hit_ent_reg;
    logic [AW:0]   clr_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    ctt_pkg::entry_t   ram_wdata, ram_rdata;

    logic        out_valid_reg;
    logic        found_reg;
    logic [15:0] hv_reg, he_reg, hm_reg;
    logic [1:0]  hb_reg;
    logic [6:0]  hd_reg;
    logic        hp_reg;

    ctt_entry_ram #(.DEPTH(SLOTS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    // Cluster index from the scaled key
    logic [CW-1:0] cu_eff;
    logic [CW+31:0] prod;
    logic [CW-1:0]  cl_idx;
    assign cu_eff = (32'(cfg_reg.clusters_in_use) > 32'(CLUSTERS))
                    ? CW'(CLUSTERS) : CW'(cfg_reg.clusters_in_use);
    assign prod   = key_reg * cu_eff;
    assign cl_idx = prod[CW+31:32];

    // Replacement score of the entry now on the read port
    logic [7:0] age_diff;
    logic signed [9:0] cur_score;
    logic cur_empty, cur_match;
    assign age_diff  = (8'd7 + cfg_reg.generation - ram_rdata.age_bound) & 8'hFC;
    assign cur_score = $signed({3'b000, ram_rdata.depth_pv[6:0]})
                       - $signed({1'b0, age_diff, 1'b0});
    assign cur_empty = (ram_rdata.age_bound[1:0] == 2'd0);
    assign cur_match = !cur_empty && (ram_rdata.tag == key_reg[15:0]);

    // Value adjustment on the way out
    logic signed [17:0] v, plys, r50s, mv_s, mt_s, tb_s, adj;
    always_comb
    begin
        v    = 18'(signed'(hit_ent_reg.value));
        plys = $signed({10'd0, ply_reg});
        r50s = $signed({11'd0, r50_reg});
        mv_s = $signed({3'd0, cfg_reg.mate_value});
        mt_s = $signed({3'd0, cfg_reg.mate_threshold});
        tb_s = $signed({3'd0, cfg_reg.tablebase_threshold});
        if (hit_ent_reg.value == cfg_reg.none_value)
            adj = v;
        else if (v >= mt_s)
            adj = (mv_s - v > 18'sd100 - r50s) ? mt_s - 18'sd1 : v - plys;
        else if (v <= -mt_s)
            adj = (mv_s + v > 18'sd100 - r50s) ? -mt_s + 18'sd1 : v + plys;
        else if (v >= tb_s)
            adj = v - plys;
        else if (v <= -tb_s)
            adj = v + plys;
        else
            adj = v;
    end

    // Stored value and the replacement entry
    logic signed [17:0] vin, adj_in;
    logic same, keep_pv, overwrite;
    ctt_pkg::entry_t tgt, wr_ent;
    always_comb
    begin
        vin = 18'(signed'(val_reg));
        if (vin >= $signed({3'd0, cfg_reg.tablebase_threshold}))
            adj_in = vin + $signed({10'd0, ply_reg});
        else if (vin <= -$signed({3'd0, cfg_reg.tablebase_threshold}))
            adj_in = vin - $signed({10'd0, ply_reg});
        else
            adj_in = vin;
        tgt = pick_ent_reg;
        if (hit_reg)
            tgt.age_bound = {cfg_reg.generation[7:2], pick_ent_reg.age_bound[1:0]};
        same      = (tgt.tag == key_reg[15:0]);
        keep_pv   = pv_reg || (same && tgt.depth_pv[7]);
        overwrite = (bnd_reg == ctt_pkg::EXACT_BOUND) || !same || (dep_reg > tgt.depth_pv[6:0]);
        wr_ent = tgt;
        if ((op_reg == ctt_pkg::OP_STORE) && ((mv_reg != 16'd0) || !same))
            wr_ent.mv = mv_reg;
        if ((op_reg == ctt_pkg::OP_STORE) && overwrite)
        begin
            wr_ent.tag       = key_reg[15:0];
            wr_ent.depth_pv  = {keep_pv, dep_reg};
            wr_ent.age_bound = {cfg_reg.generation[7:2], bnd_reg};
            wr_ent.value     = adj_in[15:0];
            wr_ent.eval      = eval_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctt_pkg::ST_CLEAR:
                if (clr_reg == (AW+1)'(SLOTS - 1))
                begin
                    if (boot_reg) state_next = ctt_pkg::ST_IDLE;
                    else state_next = ctt_pkg::ST_OUT;
                end
            ctt_pkg::ST_IDLE:
                if (in_valid && !out_valid_reg)
                begin
                    if (operation == ctt_pkg::OP_CLEAR) state_next = ctt_pkg::ST_CLEAR;
                    else if (operation inside {ctt_pkg::OP_PROBE, ctt_pkg::OP_STORE})
                        state_next = ctt_pkg::ST_INDEX;
                    else state_next = ctt_pkg::ST_OUT;
                end
            ctt_pkg::ST_INDEX: state_next = ctt_pkg::ST_READ;
            ctt_pkg::ST_READ:  state_next = ctt_pkg::ST_SCAN;
            ctt_pkg::ST_SCAN:
                if (phase_reg && idx_reg == EW'(ENTRIES_PER_CLUSTER - 1))
                    state_next = ctt_pkg::ST_WRITE;
                else
                    state_next = ctt_pkg::ST_READ;
            ctt_pkg::ST_WRITE: state_next = ctt_pkg::ST_OUT;
            ctt_pkg::ST_OUT:   state_next = ctt_pkg::ST_IDLE;
            default:           state_next = ctt_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall  = !(state_reg == ctt_pkg::ST_IDLE) || out_valid_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = wr_ent;
        addr_next = addr_reg;
        case (state_reg)
            ctt_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[AW-1:0];
                ram_wdata = '0;
            end
            ctt_pkg::ST_INDEX:
                addr_next = AW'(cl_idx * ENTRIES_PER_CLUSTER);
            ctt_pkg::ST_SCAN:
                if (!phase_reg) addr_next = addr_reg;
                else addr_next = AW'(base_reg + AW'(idx_reg) + AW'(1));
            ctt_pkg::ST_WRITE:
            begin
                ram_we    = hit_reg || (op_reg == ctt_pkg::OP_STORE);
                ram_waddr = AW'(base_reg + AW'(pick_reg));
            end
            default: addr_next = addr_reg;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctt_pkg::ST_CLEAR;
            boot_reg  <= 1'b1;
            clr_reg   <= '0;
            cfg_reg   <= '{8'd0, 13'd4096, 15'd32000, 15'd31754, 15'd31507, 16'sd32002};
            out_valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ctt_pkg::ST_IDLE) boot_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    ctt_pkg::REG_GENERATION:
                        if (state_reg != ctt_pkg::ST_CLEAR)
                            cfg_reg.generation <= {cfg_data[7:2], 2'b00};
                    ctt_pkg::REG_CLUSTERS:   cfg_reg.clusters_in_use <= cfg_data[12:0];
                    ctt_pkg::REG_MATE_VALUE: cfg_reg.mate_value <= cfg_data[14:0];
                    ctt_pkg::REG_MATE_THR:   cfg_reg.mate_threshold <= cfg_data[14:0];
                    ctt_pkg::REG_TB_THR:     cfg_reg.tablebase_threshold <= cfg_data[14:0];
                    ctt_pkg::REG_NONE_VALUE: cfg_reg.none_value <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ctt_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + (AW+1)'(1);
                cfg_reg.generation <= 8'd0;
            end
            else
            begin
                clr_reg <= '0;
            end
            if (state_reg == ctt_pkg::ST_INDEX)
            begin
                idx_reg   <= '0;
                phase_reg <= 1'b0;
            end
            else if (state_reg == ctt_pkg::ST_READ)
            begin
                phase_reg <= 1'b1;
            end
            else if (state_reg == ctt_pkg::ST_SCAN)
            begin
                phase_reg <= 1'b0;
                if (idx_reg != EW'(ENTRIES_PER_CLUSTER - 1)) idx_reg <= idx_reg + EW'(1);
            end
            if (state_reg == ctt_pkg::ST_OUT) out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (state_reg == ctt_pkg::ST_IDLE && in_valid && !in_stall)
        begin
            op_reg <= operation; key_reg <= key; val_reg <= value; eval_reg <= eval;
            mv_reg <= move; bnd_reg <= bound; dep_reg <= depth; pv_reg <= pv;
            ply_reg <= ply; r50_reg <= rule50;
            hit_reg <= 1'b0;
        end
        if (state_reg == ctt_pkg::ST_INDEX)
        begin
            base_reg <= AW'(cl_idx * ENTRIES_PER_CLUSTER);
            hit_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            pick_reg <= '0;
        end
        // Scan one entry: first match, else first empty, else lowest score
        if (state_reg == ctt_pkg::ST_SCAN && !hit_reg)
        begin
            if (cur_match)
            begin
                hit_reg <= 1'b1; pick_reg <= idx_reg;
                pick_ent_reg <= ram_rdata; hit_ent_reg <= ram_rdata;
            end
            else if (!empty_found_reg)
            begin
                if (cur_empty)
                begin
                    empty_found_reg <= 1'b1; pick_reg <= idx_reg; pick_ent_reg <= ram_rdata;
                end
                else if (idx_reg == '0 || cur_score < pick_score_reg)
                begin
                    pick_reg <= idx_reg; pick_ent_reg <= ram_rdata;
                    pick_score_reg <= cur_score;
                end
            end
        end
        if (state_reg == ctt_pkg::ST_OUT)
        begin
            found_reg <= (op_reg inside {ctt_pkg::OP_PROBE, ctt_pkg::OP_STORE}) && hit_reg;
            if (op_reg == ctt_pkg::OP_PROBE && hit_reg)
            begin
                hv_reg <= adj[15:0]; he_reg <= hit_ent_reg.eval; hm_reg <= hit_ent_reg.mv;
                hb_reg <= hit_ent_reg.age_bound[1:0];
                hd_reg <= hit_ent_reg.depth_pv[6:0]; hp_reg <= hit_ent_reg.depth_pv[7];
            end
            else
            begin
                hv_reg <= '0; he_reg <= '0; hm_reg <= '0;
                hb_reg <= '0; hd_reg <= '0; hp_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign hit_value = hv_reg;
    assign hit_eval  = he_reg;
    assign hit_move  = hm_reg;
    assign hit_bound = hb_reg;
    assign hit_depth = hd_reg;
    assign hit_pv    = hp_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ctt_pkg::ST_IDLE) |-> in_stall)
        else $error("word accepted while busy");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ctt_pkg::ST_OUT) |=> out_valid)
        else $error("result word not raised");
    a_write_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (AW+1)'(SLOTS)))
        else $error("entry write out of range");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found) && $stable(hit_value)))
        else $error("stalled result changed");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int NCLUST = 4096;
    localparam int WAYS   = 3;
    localparam int SLOTS  = NCLUST * WAYS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    typedef struct {
        logic [1:0]         op;
        logic [31:0]        k;
        logic signed [15:0] val;
        logic signed [15:0] ev;
        logic [15:0]        mv;
        logic [1:0]         bnd;
        logic [6:0]         dep;
        logic               is_pv;
        logic [7:0]         ply_dist;
        logic [6:0]         r50;
    } request_t;

    typedef struct {
        logic               fnd;
        logic signed [15:0] val;
        logic signed [15:0] ev;
        logic [15:0]        mv;
        logic [1:0]         bnd;
        logic [6:0]         dep;
        logic               is_pv;
    } lookup_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] operation;
    logic [31:0] key;
    logic signed [15:0] value, eval;
    logic [15:0] move;
    logic [1:0] bound;
    logic [6:0] depth;
    logic pv;
    logic [7:0] ply;
    logic [6:0] rule50;
    logic found;
    logic signed [15:0] hit_value, hit_eval;
    logic [15:0] hit_move;
    logic [1:0] hit_bound;
    logic [6:0] hit_depth;
    logic hit_pv;

    // shadow copy of the table and its registers
    logic [15:0] tt_tag [SLOTS];
    logic [15:0] tt_move [SLOTS];
    logic [15:0] tt_value [SLOTS];
    logic [15:0] tt_eval [SLOTS];
    logic [7:0]  tt_age_bound [SLOTS];
    logic [7:0]  tt_depth_pv [SLOTS];
    logic [7:0]  cur_gen;
    logic [12:0] cur_clusters;
    int mate_score, mate_thr, tb_thr, no_value;

    lookup_t pending_lookups[$];
    int errors;
    int cycles;
    int idle_pct, stall_pct;

    clustered_transposition_table_top i_dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // abort on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // random back-pressure on the result side
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic void wipe_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            tt_tag[i] = '0;
            tt_move[i] = '0;
            tt_value[i] = '0;
            tt_eval[i] = '0;
            tt_age_bound[i] = '0;
            tt_depth_pv[i] = '0;
        end
    endfunction

    function automatic int replace_score(int s);
        int age;
        age = (263 + int'(cur_gen) - int'(tt_age_bound[s])) & 32'hFC;
        return int'(tt_depth_pv[s][6:0]) - 2 * age;
    endfunction

    // find the slot for a key; refresh its age on a tag match
    function automatic int find_slot(logic [31:0] k, output logic hit);
        longint unsigned cu;
        int base, pick, s;
        cu = (cur_clusters > NCLUST) ? NCLUST : cur_clusters;
        base = int'((longint'(k) * cu) >> 32) * WAYS;
        pick = base;
        hit = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            s = base + i;
            if (tt_age_bound[s][1:0] != 2'd0 && tt_tag[s] == k[15:0])
            begin
                tt_age_bound[s] = {cur_gen[7:2], tt_age_bound[s][1:0]};
                hit = 1'b1;
                return s;
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            s = base + i;
            if (tt_age_bound[s][1:0] == 2'd0)
                return s;
            if (i != 0 && replace_score(s) < replace_score(pick))
                pick = s;
        end
        return pick;
    endfunction

    function automatic int score_from_search(int v, int ply_dist, int r50);
        if (v == no_value)
            return v;
        if (v >= mate_thr)
            return (mate_score - v > 100 - r50) ? mate_thr - 1 : v - ply_dist;
        if (v <= -mate_thr)
            return (mate_score + v > 100 - r50) ? -mate_thr + 1 : v + ply_dist;
        if (v >= tb_thr)
            return v - ply_dist;
        if (v <= -tb_thr)
            return v + ply_dist;
        return v;
    endfunction

    function automatic lookup_t apply_request(request_t r);
        lookup_t res;
        logic hit, same, keep_pv;
        int s, v;
        res = '{default: '0};
        case (r.op)
            ctt_pkg::OP_PROBE:
            begin
                s = find_slot(r.k, hit);
                if (hit)
                begin
                    res.fnd = 1'b1;
                    res.val = 16'(score_from_search(int'($signed(tt_value[s])),
                                                    int'(r.ply_dist), int'(r.r50)));
                    res.ev = tt_eval[s];
                    res.mv = tt_move[s];
                    res.bnd = tt_age_bound[s][1:0];
                    res.dep = tt_depth_pv[s][6:0];
                    res.is_pv = tt_depth_pv[s][7];
                end
            end
            ctt_pkg::OP_STORE:
            begin
                s = find_slot(r.k, hit);
                res.fnd = hit;
                same = (tt_tag[s] == r.k[15:0]);
                if (r.mv != 16'd0 || !same)
                    tt_move[s] = r.mv;
                keep_pv = r.is_pv || (same && tt_depth_pv[s][7]);
                if (r.bnd == ctt_pkg::EXACT_BOUND || !same || r.dep > tt_depth_pv[s][6:0])
                begin
                    v = int'(r.val);
                    if (v >= tb_thr)
                        v = v + int'(r.ply_dist);
                    else if (v <= -tb_thr)
                        v = v - int'(r.ply_dist);
                    tt_tag[s] = r.k[15:0];
                    tt_depth_pv[s] = {keep_pv, r.dep};
                    tt_age_bound[s] = {cur_gen[7:2], r.bnd};
                    tt_value[s] = 16'(v);
                    tt_eval[s] = r.ev;
                end
            end
            ctt_pkg::OP_CLEAR:
            begin
                wipe_table();
                cur_gen = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // present one word, hold it until taken, then log its expected lookup
    task automatic send(request_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        operation = r.op;
        key = r.k;
        value = r.val;
        eval = r.ev;
        move = r.mv;
        bound = r.bnd;
        depth = r.dep;
        pv = r.is_pv;
        ply = r.ply_dist;
        rule50 = r.r50;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_lookups.push_back(apply_request(r));
    endtask

    // drain, then write one register
    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_lookups.size() != 0)
            @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            ctt_pkg::REG_GENERATION: cur_gen = data[7:0] & 8'hFC;
            ctt_pkg::REG_CLUSTERS:   cur_clusters = data[12:0];
            ctt_pkg::REG_MATE_VALUE: mate_score = int'(data[14:0]);
            ctt_pkg::REG_MATE_THR:   mate_thr = int'(data[14:0]);
            ctt_pkg::REG_TB_THR:     tb_thr = int'(data[14:0]);
            ctt_pkg::REG_NONE_VALUE: no_value = int'($signed(data));
            default: ;
        endcase
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
            end
            else
            begin
                e = pending_lookups.pop_front();
                check_field("found", e.fnd, found);
                check_field("hit_value", e.val, hit_value);
                check_field("hit_eval", e.ev, hit_eval);
                check_field("hit_move", e.mv, hit_move);
                check_field("hit_bound", e.bnd, hit_bound);
                check_field("hit_depth", e.dep, hit_depth);
                check_field("hit_pv", e.is_pv, hit_pv);
            end
        end
    end

    function automatic request_t make_req(logic [1:0] op, logic [31:0] k, int v,
                                          logic [1:0] bnd, int dep, int ply_dist, int r50);
        request_t r;
        r.op = op;
        r.k = k;
        r.val = 16'(v);
        r.ev = 16'($urandom);
        r.mv = 16'($urandom_range(1, 65535));
        r.bnd = bnd;
        r.dep = 7'(dep);
        r.is_pv = 1'($urandom);
        r.ply_dist = 8'(ply_dist);
        r.r50 = 7'(r50);
        return r;
    endfunction

    task automatic test_directed();
        request_t r;
        idle_pct = 0;
        stall_pct = 0;
        send(make_req(ctt_pkg::OP_PROBE, 32'h0, 0, BOUND_NONE, 0, 0, 0));
        send(make_req(ctt_pkg::OP_STORE, 32'h1234_0042, 100, ctt_pkg::EXACT_BOUND, 10, 3, 0));
        send(make_req(ctt_pkg::OP_PROBE, 32'h1234_0042, 0, BOUND_NONE, 0, 0, 0));
        // shallower non-exact store keeps the entry; no move keeps the old move
        r = make_req(ctt_pkg::OP_STORE, 32'h1234_0042, -7, BOUND_LOWER, 5, 0, 0);
        r.mv = 16'd0;
        send(r);
        send(make_req(ctt_pkg::OP_PROBE, 32'h1234_0042, 0, BOUND_NONE, 0, 0, 0));
        // bound none leaves the slot looking empty
        send(make_req(ctt_pkg::OP_STORE, 32'h5555_0007, 55, BOUND_NONE, 9, 0, 0));
        send(make_req(ctt_pkg::OP_PROBE, 32'h5555_0007, 0, BOUND_NONE, 0, 0, 0));
        // value wrap after ply adjustment, extremes of the fields
        r = make_req(ctt_pkg::OP_STORE, 32'hFFFF_FFFF, 32767, ctt_pkg::EXACT_BOUND,
                     127, 255, 127);
        r.ev = -16'sd32768;
        r.mv = 16'hFFFF;
        r.is_pv = 1'b1;
        send(r);
        send(make_req(ctt_pkg::OP_PROBE, 32'hFFFF_FFFF, 0, BOUND_NONE, 0, 255, 127));
        // mate and tablebase distances, both signs
        send(make_req(ctt_pkg::OP_STORE, 32'h2000_0100, 31990, BOUND_UPPER, 20, 4, 0));
        send(make_req(ctt_pkg::OP_PROBE, 32'h2000_0100, 0, BOUND_NONE, 0, 2, 95));
        send(make_req(ctt_pkg::OP_PROBE, 32'h2000_0100, 0, BOUND_NONE, 0, 2, 0));
        send(make_req(ctt_pkg::OP_STORE, 32'h2000_0101, -31600, ctt_pkg::EXACT_BOUND, 8, 6, 0));
        send(make_req(ctt_pkg::OP_PROBE, 32'h2000_0101, 0, BOUND_NONE, 0, 9, 0));
        // no-value marker stored and returned untouched
        send(make_req(ctt_pkg::OP_STORE, 32'h3000_0200, 32002, ctt_pkg::EXACT_BOUND, 1, 0, 0));
        send(make_req(ctt_pkg::OP_PROBE, 32'h3000_0200, 0, BOUND_NONE, 0, 40, 60));
        send(make_req(OP_UNUSED, 32'h3000_0200, 1, ctt_pkg::EXACT_BOUND, 1, 1, 1));
        // fill one cluster and force a replacement
        for (int i = 0; i < 4; i++)
            send(make_req(ctt_pkg::OP_STORE, 32'h0000_0A00 + i, i, BOUND_LOWER, 4 - i, 0, 0));
        send(make_req(ctt_pkg::OP_PROBE, 32'h0000_0A00, 0, BOUND_NONE, 0, 0, 0));
        send(make_req(ctt_pkg::OP_CLEAR, 32'h0, 0, BOUND_NONE, 0, 0, 0));
        send(make_req(ctt_pkg::OP_PROBE, 32'h1234_0042, 0, BOUND_NONE, 0, 0, 0));
        cfg_write(REG_UNUSED, 16'hFFFF);
    endtask

    function automatic logic [31:0] pick_key();
        logic [15:0] hi_pool [4] = '{16'h0000, 16'h4000, 16'hA5A5, 16'hFFFF};
        logic [15:0] tag_pool [6] = '{16'h0000, 16'h0001, 16'h00FF, 16'h8000, 16'hC3C3,
                                      16'hFFFF};
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return {hi_pool[$urandom_range(0, 3)], tag_pool[$urandom_range(0, 5)]};
    endfunction

    function automatic int pick_score();
        case ($urandom_range(0, 6))
            0: return mate_score - $urandom_range(0, 300);
            1: return -mate_score + $urandom_range(0, 300);
            2: return tb_thr + $urandom_range(0, 10) - 5;
            3: return -tb_thr - $urandom_range(0, 10) + 5;
            4: return no_value;
            5: return $urandom_range(0, 400) - 200;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic test_random_phase(int idle, int stall, logic [15:0] gen, logic [15:0] cl,
                                     logic [15:0] mv, logic [15:0] mt, logic [15:0] tb,
                                     logic [15:0] nv, int count);
        request_t r;
        int roll;
        cfg_write(ctt_pkg::REG_GENERATION, gen);
        cfg_write(ctt_pkg::REG_CLUSTERS, cl);
        cfg_write(ctt_pkg::REG_MATE_VALUE, mv);
        cfg_write(ctt_pkg::REG_MATE_THR, mt);
        cfg_write(ctt_pkg::REG_TB_THR, tb);
        cfg_write(ctt_pkg::REG_NONE_VALUE, nv);
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 199);
            r = make_req(ctt_pkg::OP_PROBE, pick_key(), pick_score(), 2'($urandom),
                         $urandom_range(0, 127), $urandom_range(0, 255),
                         $urandom_range(0, 127));
            if (roll >= 199)
                r.op = ctt_pkg::OP_CLEAR;
            else if (roll >= 197)
                r.op = OP_UNUSED;
            else if (roll >= 90)
                r.op = ctt_pkg::OP_STORE;
            if ($urandom_range(0, 4) == 0)
                r.mv = 16'd0;
            send(r);
        end
    endtask

    initial
    begin
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = '0;
        key = '0;
        value = '0;
        eval = '0;
        move = '0;
        bound = '0;
        depth = '0;
        pv = 1'b0;
        ply = '0;
        rule50 = '0;
        wipe_table();
        cur_gen = '0;
        cur_clusters = 13'd4096;
        mate_score = 32000;
        mate_thr = 31754;
        tb_thr = 31507;
        no_value = 32002;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_phase(0, 0, 16'd4, 16'd4096, 16'd32000, 16'd31754, 16'd31507,
                          16'd32002, 350);
        test_random_phase(61, 0, 16'd255, 16'd3, 16'd32767, 16'd32000, 16'd20000,
                          16'h8000, 350);
        test_random_phase(0, 61, 16'd128, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 350);
        test_random_phase(12, 12, 16'd252, 16'd8191, 16'd32000, 16'd32767, 16'd32767,
                          16'd32767, 350);

        // let the last words drain
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_lookups.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (errors == 0 && pending_lookups.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
